// ----- src/ewds_pkg.sv -----
// Shared types, constants and helpers for the encoder delta/speed block.
// No dependencies; imported by ewds_track and encoder_wrapped_delta_speed.
`timescale 1ns / 1ps

package ewds_pkg;

   // Command carried with each sample
   typedef enum logic [1:0] {
      FUNC_UPDATE = 2'd0,
      FUNC_START  = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   // Register file layout (byte addresses)
   localparam int CSR_ADDR_W = 4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TIMER_RELOAD = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_REVERSE_DIR  = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPEED_SCALE  = 4'h8;

   // Reset values of the registers
   localparam logic [31:0] TIMER_RELOAD_RESET = 32'h0000_FFFF;

   // Width of the wrap-corrected difference: two 32-bit counts minus a
   // period of up to 2^32 needs sign plus 33 magnitude bits
   localparam int DIFF_W = 34;

   // Result of one tracking step, handed to the speed stage
   typedef struct packed {
      logic signed [31:0] delta;
      logic signed [31:0] total;
      logic               did_update;
      logic               zero_speed;
      logic               armed;
   } track_type;

   // Saturate a wide signed value to int32
   function automatic logic signed [31:0] sat32(input logic signed [DIFF_W-1:0] v);
      logic signed [DIFF_W-1:0] hi;
      logic signed [DIFF_W-1:0] lo;
      hi = DIFF_W'(32'sh7FFF_FFFF);
      lo = -DIFF_W'(33'sh0_8000_0000);
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

// ----- src/ewds_track.sv -----
// Count tracking: wrap-corrected delta, direction, saturating total, arm state.
// Depends on ewds_pkg.
`timescale 1ns / 1ps

module ewds_track import ewds_pkg::*; #(
   parameter int COUNTER_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [1:0]        func,
   input  logic [31:0]       counter_value,
   input  logic [31:0]       timer_reload,
   input  logic              reverse_direction,
   output track_type         result
);

   logic [COUNTER_BITS-1:0] prev_ff,  prev_in;
   logic signed [31:0]      total_ff, total_in;
   logic signed [31:0]      delta_ff, delta_in;
   logic                    armed_ff, armed_in;

   logic [COUNTER_BITS-1:0] cnt;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] corr;
   logic [DIFF_W-1:0]        period;
   logic signed [DIFF_W-1:0] half;
   logic signed [31:0]       wrapped;
   logic signed [31:0]       dir_delta;
   logic signed [31:0]       sum;
   logic                     did_update;
   logic                     zero_speed;

   // Raw difference and wrap correction over a period of reload + 1
   always_comb begin
      cnt    = counter_value[COUNTER_BITS-1:0];
      diff   = $signed(DIFF_W'(cnt)) - $signed(DIFF_W'(prev_ff));
      period = DIFF_W'(timer_reload) + DIFF_W'(1);
      half   = $signed(period >> 1);
      corr   = diff;
      if (timer_reload != 32'd0) begin
         if (diff > half) begin
            corr = diff - $signed(period);
         end else if (diff < -half) begin
            corr = diff + $signed(period);
         end
      end
      wrapped = sat32(corr);
   end

   // Direction and running total
   always_comb begin
      if (reverse_direction) begin
         dir_delta = sat32(-DIFF_W'(wrapped));
      end else begin
         dir_delta = wrapped;
      end
      sum = sat32(DIFF_W'(total_ff) + DIFF_W'(dir_delta));
   end

   // Next state per command
   always_comb begin
      prev_in    = prev_ff;
      total_in   = total_ff;
      delta_in   = delta_ff;
      armed_in   = armed_ff;
      did_update = 1'b0;
      zero_speed = 1'b0;
      case (func_type'(func)) inside
         FUNC_UPDATE: begin
            if (armed_ff) begin
               prev_in    = cnt;
               delta_in   = dir_delta;
               total_in   = sum;
               did_update = 1'b1;
            end
         end
         FUNC_START, FUNC_CLEAR: begin
            prev_in    = cnt;
            delta_in   = '0;
            total_in   = '0;
            zero_speed = 1'b1;
            if (func_type'(func) == FUNC_START) begin
               armed_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.delta      = delta_in;
      result.total      = total_in;
      result.did_update = did_update;
      result.zero_speed = zero_speed;
      result.armed      = armed_ff;
   end

   // Commit state when the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         total_ff <= '0;
         delta_ff <= '0;
         armed_ff <= 1'b0;
      end else if (step_en) begin
         prev_ff  <= prev_in;
         total_ff <= total_in;
         delta_ff <= delta_in;
         armed_ff <= armed_in;
      end
   end

endmodule

// ----- src/encoder_wrapped_delta_speed.sv -----
// Top level of the encoder delta/speed block: stream channels, register port,
// three-stage pipeline. Depends on ewds_pkg and ewds_track.
`timescale 1ns / 1ps

// Usage
//   req channel: one transaction per encoder sample; tuser carries the command
//   (update, start, clear), tdata the raw timer count.
//   rsp channel: exactly one transaction per request, carrying the held delta,
//   running total, speed (signed Q48.16) and the did_update flag.
//   csr port: timer_reload at 0x0, reverse_direction at 0x4, speed_scale at
//   0x8; write only while the block is idle.
// Path: an accepted request passes through the input register, the tracking
//   stage and the multiply/output register before its response is valid.
// Throughput: one transaction per cycle while rsp_tready is high; the tracking
//   update and the 32x33 multiply each sit in their own stage.
// Reset: registers return to their reset values, the block is disarmed and
//   all held values are zero; updates are ignored until a start command.
// Stall: while rsp_tready is low the response holds and the pipeline fills;
//   req_tready drops only once all three stages hold transactions.

module encoder_wrapped_delta_speed import ewds_pkg::*; #(
   parameter int COUNTER_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] counter_value
   input  logic [1:0]            req_tuser,   // [1:0] func
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,   // [31:0] count_change, [63:32] total_count,
                                              // [127:64] speed_value
   output logic [0:0]            rsp_tuser,   // [0] did_update
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Registers
   logic [31:0] reload_ff;
   logic        reverse_ff;
   logic [31:0] scale_ff;
   logic        csr_wr;

   // Stage 1: input register
   logic        s1_valid_ff;
   logic [1:0]  s1_func_ff;
   logic [31:0] s1_count_ff;
   // Stage 2: tracking result
   logic        s2_valid_ff;
   track_type   s2_ff;
   // Stage 3: output register
   logic               s3_valid_ff;
   logic signed [31:0] s3_delta_ff;
   logic signed [31:0] s3_total_ff;
   logic signed [63:0] s3_speed_ff, s3_speed_in;
   logic               s3_update_ff;

   logic        adv1, adv2, adv3;
   logic        rdy1, rdy2, rdy3;
   track_type   track_res;
   logic signed [64:0] product;

   // Register write and readback
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff  <= TIMER_RELOAD_RESET;
         reverse_ff <= 1'b0;
         scale_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr)
            ADDR_TIMER_RELOAD: reload_ff  <= csr_pwdata;
            ADDR_REVERSE_DIR:  reverse_ff <= csr_pwdata[0];
            ADDR_SPEED_SCALE:  scale_ff   <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_TIMER_RELOAD: csr_prdata = reload_ff;
         ADDR_REVERSE_DIR:  csr_prdata = {31'd0, reverse_ff};
         ADDR_SPEED_SCALE:  csr_prdata = scale_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // Stall chain: a stage advances when the next one is free or draining
   assign rdy3 = !s3_valid_ff || rsp_tready;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign req_tready = rdy1;
   assign adv1 = req_tvalid && rdy1;
   assign adv2 = s1_valid_ff && rdy2;
   assign adv3 = s2_valid_ff && rdy3;

   // Count tracking between stage 1 and stage 2
   ewds_track #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_track (
      .clock             (clock),
      .reset             (reset),
      .step_en           (adv2),
      .func              (s1_func_ff),
      .counter_value     (s1_count_ff),
      .timer_reload      (reload_ff),
      .reverse_direction (reverse_ff),
      .result            (track_res)
   );

   // Speed multiply between stage 2 and 3; zero on start/clear, else hold the last speed
   assign product = $signed(65'(s2_ff.delta)) * $signed({33'd0, scale_ff});

   always_comb begin
      if (s2_ff.did_update) begin
         s3_speed_in = product[63:0];
      end else if (s2_ff.zero_speed) begin
         s3_speed_in = '0;
      end else begin
         s3_speed_in = s3_speed_ff;
      end
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= req_tvalid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_func_ff  <= req_tuser;
         s1_count_ff <= req_tdata;
      end
      if (adv2) begin
         s2_ff <= track_res;
      end
   end

   // Output register doubles as the held speed, so it is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_delta_ff  <= '0;
         s3_total_ff  <= '0;
         s3_speed_ff  <= '0;
         s3_update_ff <= 1'b0;
      end else if (adv3) begin
         s3_delta_ff  <= s2_ff.delta;
         s3_total_ff  <= s2_ff.total;
         s3_speed_ff  <= s3_speed_in;
         s3_update_ff <= s2_ff.did_update;
      end
   end

   assign rsp_tvalid   = s3_valid_ff;
   assign rsp_tdata    = {s3_speed_ff, s3_total_ff, s3_delta_ff};
   assign rsp_tuser[0] = s3_update_ff;

   // An empty output stage always leaves the request side open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s3_valid_ff |-> req_tready)
      else $error("request side stalled with empty output stage");

   // An applied update implies the block was armed
   a_update_needs_arm: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_ff.did_update) |-> s2_ff.armed)
      else $error("update reported while disarmed");

   // A zero delta update gives zero speed
   a_zero_delta_speed: assert property (@(posedge clock) disable iff (reset)
      (adv3 && s2_ff.did_update && s2_ff.delta == 32'sd0) |=> (s3_speed_ff == 64'sd0))
      else $error("nonzero speed for zero count change");

endmodule
